### design/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg: shared types, codes and round functions of the SHA-256 hasher
// Holds the request codes, status codes, sequencer states, the round
// constant and initial vector tables, and the sigma helper functions.
// ----------------------------------------------------------------------------
package sbsh_pkg;

	typedef enum logic [1:0] {
		OP_ABSORB   = 2'd0,
		OP_FINALIZE = 2'd1,
		OP_READ     = 2'd2,
		OP_RESET    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LOAD,
		S_ROUND,
		S_FOLD,
		S_EMIT_RD,
		S_EMIT_WR
	} state_t;

	localparam logic [7:0]  PAD_MARK   = 8'h80;
	localparam logic [31:0] LEN_LIMIT  = 32'hFFFF_FFF7;
	localparam logic [5:0]  LAST_BYTE  = 6'd63;
	localparam logic [5:0]  LAST_ROUND = 6'd63;
	localparam logic [5:0]  LOAD_END   = 6'd16;
	localparam logic [5:0]  FOLD_END   = 6'd8;
	localparam logic [5:0]  LEN_START  = 6'd56;
	localparam logic [3:0]  LAST_WORD  = 4'd15;

	function automatic logic [31:0] sbsh_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] sbsh_iv(input logic [2:0] i);
		logic [31:0] v;
		case (i)
			3'd0: v = 32'h6A09E667; 3'd1: v = 32'hBB67AE85;
			3'd2: v = 32'h3C6EF372; 3'd3: v = 32'hA54FF53A;
			3'd4: v = 32'h510E527F; 3'd5: v = 32'h9B05688C;
			3'd6: v = 32'h1F83D9AB; 3'd7: v = 32'h5BE0CD19;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

### design/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher: SHA-256 over a stream of message bytes
// Message words sit in a 16-word block RAM, chaining words in an 8-word RAM.
// A sequencer pads, loads, runs 64 rounds and folds back into the chain RAM.
//
//   channel | direction | fields                                  | handshake
//   in      | input     | operation, data_byte                    | in_valid/in_ready
//   out     | output    | digest_word, word_index, last_word,     | out_valid/out_ready
//           |           | status                                  |
//
// An absorb is taken while the sequencer idles; every 64th byte adds a
// compression of load, round and fold steps, and requests wait meanwhile.
// Finalize pads the block, compresses once or twice, then emits eight
// words, each read from the chain RAM port before it is registered.
// Reset clears all control state; the chain RAM reads as the initial vector
// until the first fold. Requests wait while the output register is full.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
	import sbsh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic [1:0]  status
);

	state_t      state_q, state_d;
	logic [5:0]  fill_q;
	logic [31:0] bitlen_q;
	logic        done_q;
	logic [1:0]  err_q;
	logic        chain_iv_q;
	logic [23:0] part_q;
	logic [5:0]  cnt_q;
	logic [3:0]  pad_addr_q;
	logic        mark_q;
	logic        second_q;
	logic        fin_q;
	logic [2:0]  emit_q;
	logic [2:0]  chain_raddr_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];

	logic        out_valid_q;
	logic [31:0] word_q;
	logic [2:0]  index_q;
	logic        last_q;
	logic [1:0]  status_q;

	logic        out_free, acc;
	logic        blk_we, blk_re, ch_we, ch_re;
	logic [3:0]  blk_waddr;
	logic [31:0] blk_wdata, blk_rd;
	logic [2:0]  ch_waddr, ch_raddr;
	logic [31:0] ch_wdata, ch_ram_rd, ch_rd;
	logic [31:0] mark_word, pad_word, t1, t2, w_new;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign acc      = in_valid && in_ready;

	assign out_valid   = out_valid_q;
	assign digest_word = word_q;
	assign word_index  = index_q;
	assign last_word   = last_q;
	assign status      = status_q;

	// chain words read as the initial vector until the first fold completes
	assign ch_rd = chain_iv_q ? sbsh_iv(chain_raddr_q) : ch_ram_rd;

	// build the pad words: the word that carries the pad mark, the bit length and zeros
	always_comb begin
		case (fill_q[1:0])
			2'd0:    mark_word = {PAD_MARK, 24'h0};
			2'd1:    mark_word = {part_q[7:0], PAD_MARK, 16'h0};
			2'd2:    mark_word = {part_q[15:0], PAD_MARK, 8'h0};
			default: mark_word = {part_q, PAD_MARK};
		endcase
		if (mark_q) begin
			pad_word = mark_word;
		end else if (pad_addr_q == LAST_WORD && !second_q) begin
			pad_word = bitlen_q;
		end else begin
			pad_word = 32'h0;
		end
	end

	// round and schedule arithmetic
	always_comb begin
		t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sbsh_k(cnt_q) + w_q[0];
		t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && operation != OP_RESET && err_q == ST_OK) begin
					case (operation)
						OP_ABSORB: begin
							if (!done_q && bitlen_q <= LEN_LIMIT && fill_q == LAST_BYTE) begin
								state_d = S_LOAD;
							end
						end
						OP_FINALIZE: begin
							if (!done_q) begin
								state_d = S_PAD;
							end
						end
						default: begin
							state_d = done_q ? S_EMIT_RD : S_PAD;
						end
					endcase
				end
			end
			S_PAD: begin
				if (pad_addr_q == LAST_WORD) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (cnt_q == LOAD_END) begin
					state_d = S_ROUND;
				end
			end
			S_ROUND: begin
				if (cnt_q == LAST_ROUND) begin
					state_d = S_FOLD;
				end
			end
			S_FOLD: begin
				if (cnt_q == FOLD_END) begin
					if (fin_q && second_q) begin
						state_d = S_PAD;
					end else if (fin_q) begin
						state_d = S_EMIT_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT_RD: state_d = S_EMIT_WR;
			S_EMIT_WR: begin
				if (out_free) begin
					state_d = (emit_q == 3'd7) ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		blk_we    = 1'b0;
		blk_waddr = fill_q[5:2];
		blk_wdata = {part_q, data_byte};
		blk_re    = 1'b0;
		ch_we     = 1'b0;
		ch_waddr  = 3'(cnt_q - 6'd1);
		ch_wdata  = ch_rd + v_q[0];
		ch_re     = 1'b0;
		ch_raddr  = cnt_q[2:0];
		case (state_q)
			S_IDLE: begin
				blk_we = acc && operation == OP_ABSORB && err_q == ST_OK && !done_q
					&& bitlen_q <= LEN_LIMIT && fill_q[1:0] == 2'd3;
			end
			S_PAD: begin
				blk_we    = 1'b1;
				blk_waddr = pad_addr_q;
				blk_wdata = pad_word;
			end
			S_LOAD: begin
				blk_re = cnt_q < LOAD_END;
				ch_re  = cnt_q < FOLD_END;
			end
			S_FOLD: begin
				ch_re = cnt_q < FOLD_END;
				ch_we = cnt_q != 6'd0;
			end
			S_EMIT_RD: begin
				ch_re    = 1'b1;
				ch_raddr = emit_q;
			end
			default: begin
			end
		endcase
	end

	sbsh_ram #(.WIDTH(32), .DEPTH(16)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.re    (blk_re),
		.raddr (cnt_q[3:0]),
		.rdata (blk_rd)
	);

	sbsh_ram #(.WIDTH(32), .DEPTH(8)) u_chain_ram (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.re    (ch_re),
		.raddr (ch_raddr),
		.rdata (ch_ram_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			bitlen_q    <= '0;
			done_q      <= 1'b0;
			err_q       <= ST_OK;
			chain_iv_q  <= 1'b1;
			cnt_q       <= '0;
			pad_addr_q  <= '0;
			mark_q      <= 1'b0;
			second_q    <= 1'b0;
			fin_q       <= 1'b0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (acc) begin
						if (operation == OP_RESET) begin
							fill_q     <= '0;
							bitlen_q   <= '0;
							done_q     <= 1'b0;
							err_q      <= ST_OK;
							chain_iv_q <= 1'b1;
						end else if (err_q != ST_OK) begin
							out_valid_q <= 1'b1;
						end else if (operation == OP_ABSORB) begin
							if (done_q) begin
								out_valid_q <= 1'b1;
							end else if (bitlen_q > LEN_LIMIT) begin
								err_q       <= ST_TOO_LONG;
								out_valid_q <= 1'b1;
							end else begin
								fill_q   <= fill_q + 6'd1;
								bitlen_q <= bitlen_q + 32'd8;
							end
						end else if (operation == OP_FINALIZE && done_q) begin
							out_valid_q <= 1'b1;
						end else if (done_q) begin
							emit_q <= '0;
						end else begin
							fin_q      <= 1'b1;
							mark_q     <= 1'b1;
							pad_addr_q <= fill_q[5:2];
							second_q   <= fill_q >= LEN_START;
							emit_q     <= '0;
						end
					end
				end
				S_PAD: begin
					mark_q     <= 1'b0;
					pad_addr_q <= pad_addr_q + 4'd1;
					cnt_q      <= '0;
				end
				S_LOAD: begin
					cnt_q <= (cnt_q == LOAD_END) ? 6'd0 : cnt_q + 6'd1;
				end
				S_ROUND: begin
					cnt_q <= (cnt_q == LAST_ROUND) ? 6'd0 : cnt_q + 6'd1;
				end
				S_FOLD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == FOLD_END) begin
						cnt_q      <= '0;
						chain_iv_q <= 1'b0;
						fill_q     <= '0;
						if (fin_q && second_q) begin
							second_q   <= 1'b0;
							pad_addr_q <= '0;
						end else if (fin_q) begin
							fin_q    <= 1'b0;
							done_q   <= 1'b1;
							bitlen_q <= '0;
						end
					end
				end
				S_EMIT_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						emit_q      <= emit_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload: partial word, window, working variables, output
	always_ff @(posedge clk) begin
		if (ch_re) begin
			chain_raddr_q <= ch_raddr;
		end
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (operation == OP_ABSORB) begin
						part_q <= {part_q[15:0], data_byte};
					end
					word_q   <= '0;
					index_q  <= '0;
					last_q   <= 1'b1;
					status_q <= (err_q != ST_OK) ? err_q
						: (operation == OP_ABSORB && !done_q) ? ST_TOO_LONG : ST_INVALID;
				end
			end
			S_LOAD: begin
				if (cnt_q != 6'd0) begin
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i+1];
					end
					w_q[15] <= blk_rd;
				end
				if (cnt_q != 6'd0 && cnt_q <= FOLD_END) begin
					for (int i = 0; i < 7; i++) begin
						v_q[i] <= v_q[i+1];
					end
					v_q[7] <= ch_rd;
				end
			end
			S_ROUND: begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			S_FOLD: begin
				if (cnt_q != 6'd0) begin
					for (int i = 0; i < 7; i++) begin
						v_q[i] <= v_q[i+1];
					end
					v_q[7] <= v_q[0];
				end
			end
			S_EMIT_WR: begin
				if (out_free) begin
					word_q   <= ch_rd;
					index_q  <= emit_q;
					last_q   <= emit_q == 3'd7;
					status_q <= ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// requests are taken only by the idle sequencer
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("request taken while sequencer busy");

	// block RAM is written only by absorb or padding
	a_blk_write: assert property (@(posedge clk) disable iff (!arst_n)
		blk_we |-> (state_q == S_IDLE || state_q == S_PAD))
		else $error("block RAM written outside absorb or pad");

	// a stalled digest word waits in place
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_WR && !out_free) |=> state_q == S_EMIT_WR)
		else $error("digest word dropped under stall");

	// a finished message holds no buffered bytes
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> fill_q == 6'd0)
		else $error("bytes buffered after finalize");

endmodule

### design/sbsh_ram.sv
// ----------------------------------------------------------------------------
// sbsh_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module sbsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### verif/sha256_byte_stream_hasher_test.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_test: self-checking bench for the SHA-256 hasher
// Drives absorb, finalize, read and reset requests with random gaps and
// output stalls. An internal SHA-256 predictor models the digest, sticky
// errors and the finalized state. Every returned word is checked in order.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_test
	import sbsh_pkg::*;
();

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_REQUESTS = 500;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
		logic [1:0]  code;
	} digest_result_t;

	// SHA-256 predictor and ordered store of expected digest words
	class sha_scoreboard;
		logic [31:0] round_const[64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		logic [31:0] start_hash[8] = '{
			32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
			32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

		logic [31:0] hash[8];
		logic [7:0]  msg_block[64];
		int unsigned held_bytes;
		logic [31:0] msg_bits;
		bit          finalized;
		status_t     sticky;
		digest_result_t pending_words[$];
		int unsigned failures;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			hash = start_hash;
			foreach (msg_block[i]) msg_block[i] = 8'h00;
			held_bytes = 0;
			msg_bits = 32'h0;
			finalized = 1'b0;
			sticky = ST_OK;
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// run the 64 rounds on the held block and fold into the hash
		function void compress();
			logic [31:0] w[64];
			logic [31:0] v[8];
			logic [31:0] t1, t2, e, a;
			for (int i = 0; i < 16; i++)
				w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
			for (int i = 16; i < 64; i++)
				w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
			v = hash;
			for (int i = 0; i < 64; i++) begin
				e = v[4];
				a = v[0];
				t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
					+ round_const[i] + w[i];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = e; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = a; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) hash[i] = hash[i] + v[i];
			held_bytes = 0;
		endfunction

		// pad with the marker, zeros and the bit count, then compress
		function void pad_and_close();
			msg_block[held_bytes] = 8'h80;
			for (int i = held_bytes + 1; i < 64; i++) msg_block[i] = 8'h00;
			if (held_bytes >= 56) begin
				compress();
				foreach (msg_block[i]) msg_block[i] = 8'h00;
			end
			for (int i = 56; i < 60; i++) msg_block[i] = 8'h00;
			{msg_block[60], msg_block[61], msg_block[62], msg_block[63]} = msg_bits;
			compress();
			foreach (msg_block[i]) msg_block[i] = 8'h00;
			held_bytes = 0;
			finalized = 1'b1;
			msg_bits = 32'h0;
		endfunction

		function void push_error(status_t c);
			digest_result_t r;
			r.word = 32'h0; r.index = 3'd0; r.last = 1'b1; r.code = c;
			pending_words.push_back(r);
		endfunction

		function void push_digest();
			digest_result_t r;
			for (int i = 0; i < 8; i++) begin
				r.word = hash[i]; r.index = i[2:0]; r.last = (i == 7); r.code = ST_OK;
				pending_words.push_back(r);
			end
		endfunction

		// predict the words one accepted request produces
		function void note_request(op_t op, logic [7:0] data);
			if (op == OP_RESET) begin
				restart();
				return;
			end
			if (sticky != ST_OK) begin
				push_error(sticky);
				return;
			end
			case (op)
				OP_ABSORB: begin
					if (finalized)
						push_error(ST_INVALID);
					else if (msg_bits > 32'hFFFF_FFF7) begin
						sticky = ST_TOO_LONG;
						push_error(ST_TOO_LONG);
					end else begin
						msg_block[held_bytes] = data;
						held_bytes++;
						msg_bits += 32'd8;
						if (held_bytes == 64) compress();
					end
				end
				OP_FINALIZE: begin
					if (finalized)
						push_error(ST_INVALID);
					else begin
						pad_and_close();
						push_digest();
					end
				end
				default: begin
					if (!finalized) pad_and_close();
					push_digest();
				end
			endcase
		endfunction

		// compare one returned word with the oldest prediction
		function void check_result(logic [31:0] word, logic [2:0] index, logic last,
			logic [1:0] code);
			digest_result_t r;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word=%h index=%0d last=%b status=%0d",
					$time, word, index, last, code);
				failures++;
				return;
			end
			r = pending_words.pop_front();
			if (word !== r.word) begin
				$display("%0t: digest_word expected %h actual %h", $time, r.word, word);
				failures++;
			end
			if (index !== r.index) begin
				$display("%0t: word_index expected %0d actual %0d", $time, r.index, index);
				failures++;
			end
			if (last !== r.last) begin
				$display("%0t: last_word expected %b actual %b", $time, r.last, last);
				failures++;
			end
			if (code !== r.code) begin
				$display("%0t: status expected %0d actual %0d", $time, r.code, code);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic [1:0]  status;

	sha_scoreboard digests;
	bit steady;
	int unsigned cycles;
	int unsigned sent;

	sha256_byte_stream_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index),
		.last_word(last_word), .status(status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, a few long ones, none while steady
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// stall the result side at random
	always @(negedge clk) begin
		if (steady || $urandom_range(0, 99) < 65)
			out_ready <= 1'b1;
		else if ($urandom_range(0, 9) == 0)
			out_ready <= 1'b0;
		else
			out_ready <= $urandom_range(0, 1);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			digests.check_result(digest_word, word_index, last_word, status);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sha256_byte_stream_hasher: mismatch");
			$finish;
		end
	end

	// hold one request until the block takes it
	task automatic send_request(op_t op, logic [7:0] data);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= data;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		digests.note_request(op, data);
		sent++;
	endtask

	task automatic send_message(int unsigned len);
		for (int i = 0; i < len; i++)
			send_request(OP_ABSORB, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int unsigned len;
		digests = new();
		cycles = 0;
		sent = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ABSORB;
		data_byte = 8'h00;
		out_ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty message, repeated read, requests after finalize
		send_request(OP_FINALIZE, 8'h00);
		send_request(OP_READ, 8'h00);
		send_request(OP_ABSORB, 8'hFF);
		send_request(OP_FINALIZE, 8'h00);
		send_request(OP_RESET, 8'hA5);
		// read finalizes an open message
		send_request(OP_ABSORB, 8'h00);
		send_request(OP_ABSORB, 8'hFF);
		send_request(OP_ABSORB, 8'h55);
		send_request(OP_READ, 8'h00);
		send_request(OP_READ, 8'h00);
		send_request(OP_RESET, 8'h00);
		// padding just below and at the length field start, and a full block
		send_message(55);
		send_request(OP_FINALIZE, 8'h00);
		send_request(OP_RESET, 8'h00);
		send_message(56);
		send_request(OP_FINALIZE, 8'h00);
		send_request(OP_RESET, 8'h00);
		send_message(64);
		send_request(OP_READ, 8'h00);
		send_request(OP_RESET, 8'h00);

		// well-formed messages with random content, plus noise
		while (sent < RANDOM_REQUESTS) begin
			steady = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 4) != 0) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 140)
					: $urandom_range(0, 63);
				send_message(len);
				send_request($urandom_range(0, 1) ? OP_FINALIZE : OP_READ, 8'h00);
				if ($urandom_range(0, 3) == 0)
					send_request(op_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
				send_request(OP_RESET, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6))
					send_request(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
		steady = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (digests.pending_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (digests.failures == 0)
			$display("sha256_byte_stream_hasher: match");
		else
			$display("sha256_byte_stream_hasher: mismatch");
		$finish;
	end

endmodule

### filelist.f
design/sbsh_pkg.sv
design/sbsh_ram.sv
design/sha256_byte_stream_hasher.sv
verif/sha256_byte_stream_hasher_test.sv
